>>> sv/gfca_pkg.sv
// Package for the gated frequency counter with moving-average window.
// Holds widths, window constants, divider constants and stage payload types.
// No dependencies.
package gfca_pkg;

    localparam int PULSE_W          = 16;
    localparam int FREQ_W           = 20;
    localparam int PAIR_W           = 18;

    localparam int WINDOW_SECONDS   = 3;
    localparam int SLOTS_PER_SECOND = 5;
    localparam int RING_DEPTH       = WINDOW_SECONDS * SLOTS_PER_SECOND;

    // largest pair sum: two full-scale counts
    localparam int PAIR_MAX   = 2 * (2 ** PULSE_W - 1);
    localparam int SUM_W      = $clog2(RING_DEPTH * PAIR_MAX + 1);
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUB_W      = (SLOTS_PER_SECOND > 1) ? $clog2(SLOTS_PER_SECOND) : 1;
    localparam int WARM_W     = $clog2(WINDOW_SECONDS + 2);
    localparam int WARM_DONE  = WINDOW_SECONDS + 1;

    localparam int INSTANT_GAIN = 5;

    // floor(x / WINDOW_SECONDS) = (x * DIV_RECIP) >> DIV_SHIFT for any SUM_W-bit x
    localparam int    DIV_SHIFT = SUM_W + $clog2(WINDOW_SECONDS);
    localparam int    RECIP_W   = DIV_SHIFT + 1;
    localparam int    PROD_W    = SUM_W + RECIP_W;
    localparam longint DIV_RECIP =
        ((longint'(1) << DIV_SHIFT) + longint'(WINDOW_SECONDS) - 1) / WINDOW_SECONDS;

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    typedef logic [PAIR_W-1:0] pair_t;
    typedef logic [SUM_W-1:0]  wsum_t;

    typedef struct packed {
        logic [FREQ_W-1:0] instant_freq;
        wsum_t             window_sum;
        logic              mean_valid;
    } acc_result_t;

endpackage

>>> sv/gfca_accum.sv
// Pair accumulation, warm-up tracking, slot ring and running window sum.
// One count per cycle unless a held output stalls it; emits a registered beat
// on the second count of a pair. Depends on gfca_pkg.
module gfca_accum import gfca_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [PULSE_W-1:0] in_count,
    output logic               in_ready,
    output logic               out_valid,
    output acc_result_t        out_data,
    input  logic               out_ready
);

    logic              phase_reg, phase_next;
    pair_t             pair_sum_reg, pair_sum_next;
    logic [WARM_W-1:0] warm_reg, warm_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SUB_W-1:0]  sub_reg, sub_next;
    wsum_t             wsum_reg, wsum_next;
    logic              valid_reg, valid_next;
    acc_result_t       data_reg, data_next;

    pair_t             ring [RING_DEPTH];

    logic              take;
    pair_t             pair_new;
    logic              warm_done;
    logic [FREQ_W-1:0] instant;

    assign take     = !valid_reg || out_ready;
    assign in_ready = take;

    assign pair_new = pair_sum_reg + pair_t'(in_count);
    assign instant  = FREQ_W'(pair_new) * FREQ_W'(INSTANT_GAIN);

    always_comb begin
        phase_next    = phase_reg;
        pair_sum_next = pair_sum_reg;
        warm_next     = warm_reg;
        slot_next     = slot_reg;
        sub_next      = sub_reg;
        wsum_next     = wsum_reg;
        valid_next    = valid_reg && !out_ready;
        data_next     = data_reg;
        warm_done     = 1'b0;

        if (in_valid && take) begin
            if (!phase_reg) begin
                phase_next    = 1'b1;
                pair_sum_next = pair_new;
            end else begin
                phase_next    = 1'b0;
                pair_sum_next = '0;
                // warm-up steps on the first slot of each second
                if (warm_reg != WARM_W'(WARM_DONE) && sub_reg == '0)
                    warm_next = warm_reg + WARM_W'(1);
                warm_done = (warm_next == WARM_W'(WARM_DONE));
                if (warm_done)
                    wsum_next = wsum_reg + wsum_t'(pair_new) - wsum_t'(ring[slot_reg]);
                else
                    wsum_next = wsum_reg + wsum_t'(pair_new);

                slot_next = (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
                sub_next  = (sub_reg == SUB_W'(SLOTS_PER_SECOND - 1)) ? '0 : sub_reg + SUB_W'(1);

                valid_next             = 1'b1;
                data_next.instant_freq = instant;
                data_next.window_sum   = wsum_next;
                data_next.mean_valid   = warm_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 1'b0;
            pair_sum_reg <= '0;
            warm_reg     <= '0;
            slot_reg     <= '0;
            sub_reg      <= '0;
            wsum_reg     <= '0;
            valid_reg    <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            pair_sum_reg <= pair_sum_next;
            warm_reg     <= warm_next;
            slot_reg     <= slot_next;
            sub_reg      <= sub_next;
            wsum_reg     <= wsum_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (in_valid && take && phase_reg)
            ring[slot_reg] <= pair_new;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/gfca_mean.sv
// Mean stage: window sum divided by the window length via reciprocal multiply,
// saturated to the result width, into the output register. Depends on gfca_pkg.
module gfca_mean import gfca_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  acc_result_t       in_data,
    output logic              in_ready,
    output logic              out_valid,
    output logic [FREQ_W-1:0] out_instant,
    output logic [FREQ_W-1:0] out_mean,
    output logic              out_mean_valid,
    input  logic              out_ready
);

    logic              valid_reg, valid_next;
    logic [FREQ_W-1:0] instant_reg;
    logic [FREQ_W-1:0] mean_reg, mean_calc;
    logic              mvalid_reg;

    logic              take;
    logic [PROD_W-1:0] prod;
    wsum_t             quot;

    assign take     = !valid_reg || out_ready;
    assign in_ready = take;

    assign prod = PROD_W'(in_data.window_sum) * PROD_W'(DIV_RECIP);
    assign quot = SUM_W'(prod >> DIV_SHIFT);

    always_comb begin
        valid_next = valid_reg && !out_ready;
        if (in_valid && take)
            valid_next = 1'b1;
        if (!in_data.mean_valid)
            mean_calc = '0;
        else if (quot > wsum_t'(FREQ_MAX))
            mean_calc = FREQ_MAX;
        else
            mean_calc = FREQ_W'(quot);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (in_valid && take) begin
            instant_reg <= in_data.instant_freq;
            mean_reg    <= mean_calc;
            mvalid_reg  <= in_data.mean_valid;
        end
    end

    assign out_valid      = valid_reg;
    assign out_instant    = instant_reg;
    assign out_mean       = mean_reg;
    assign out_mean_valid = mvalid_reg;

endmodule

>>> sv/gated_frequency_counter_average.sv
// Gated frequency counter with moving-average window (top level).
// Throughput: one count per cycle while m_tready does not stall the pipeline;
// one result beat per two counts.
// Stages: input register, accumulate/ring update, reciprocal divide + output register.
// Reset (aresetn low, synchronous): pair phase, warm-up, slot pointer and window sum
// cleared, pipeline emptied; ring contents are not cleared and need no clearing pass.
module gated_frequency_counter_average import gfca_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pulse_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [19:0] instant_freq, [39:20] mean_freq
    output logic        m_tuser    // [0] mean_valid
);

    logic               in_valid_reg;
    logic [PULSE_W-1:0] in_count_reg;
    logic               acc_ready;
    logic               take;

    logic               acc_valid;
    acc_result_t        acc_data;
    logic               mean_ready;

    logic [FREQ_W-1:0]  instant;
    logic [FREQ_W-1:0]  mean;

    assign take     = !in_valid_reg || acc_ready;
    assign s_tready = take;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else if (take)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (take && s_tvalid)
            in_count_reg <= s_tdata[PULSE_W-1:0];
    end

    gfca_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_count  (in_count_reg),
        .in_ready  (acc_ready),
        .out_valid (acc_valid),
        .out_data  (acc_data),
        .out_ready (mean_ready)
    );

    gfca_mean u_mean (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (acc_valid),
        .in_data        (acc_data),
        .in_ready       (mean_ready),
        .out_valid      (m_tvalid),
        .out_instant    (instant),
        .out_mean       (mean),
        .out_mean_valid (m_tuser),
        .out_ready      (m_tready)
    );

    assign m_tdata = {mean, instant};

endmodule

>>> dv/tb_gated_frequency_counter_average.sv
`timescale 1ns / 100ps
// Self-checking testbench for gated_frequency_counter_average: streams pulse counts
// with random idling and checks every reading against an in-bench model of the counter.
// Depends on gfca_pkg and the gated_frequency_counter_average RTL.
module tb_gated_frequency_counter_average;
    import gfca_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_ITEMS    = 550;
    localparam int HOLD_OFF_AT     = 200;   // input beats before the long output stall
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int CALM_TAIL       = 60;    // last beats go out with no idling
    localparam int DRAIN_CYCLES    = 8;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [FREQ_W-1:0] instant_freq;
        logic [FREQ_W-1:0] mean_freq;
        logic              mean_valid;
    } reading_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] pulse_count
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [19:0] instant_freq, [39:20] mean_freq
    logic        m_tuser;         // [0] mean_valid

    gated_frequency_counter_average u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    logic [PULSE_W-1:0] pending_counts[$];
    reading_t           expected_readings[$];

    // counter model state
    logic            second_of_pair = 1'b0;
    pair_t           pair_acc       = '0;
    int unsigned     seconds_seen   = 0;
    int unsigned     next_slot      = 0;
    longint unsigned window_total   = 0;
    pair_t           slot_history[RING_DEPTH];

    int unsigned mismatches = 0;
    int unsigned beats_in   = 0;
    int unsigned cycles     = 0;
    logic        in_taken   = 1'b0;

    task automatic predict_count(input logic [PULSE_W-1:0] count);
        reading_t        r;
        int unsigned     slot;
        longint unsigned quotient;
        pair_acc = pair_acc + count;   // wraps at the pair width
        if (!second_of_pair) begin
            second_of_pair = 1'b1;
            return;
        end
        second_of_pair = 1'b0;
        r.instant_freq = FREQ_W'(longint'(pair_acc) * INSTANT_GAIN);
        r.mean_freq    = '0;
        r.mean_valid   = 1'b0;
        slot = (next_slot >= RING_DEPTH) ? 0 : next_slot;
        // one warm-up step per second's worth of slots
        if (seconds_seen != WARM_DONE && (slot % SLOTS_PER_SECOND) == 0)
            seconds_seen++;
        if (seconds_seen == WARM_DONE) begin
            window_total = window_total - slot_history[slot] + pair_acc;
            quotient = window_total / WINDOW_SECONDS;
            r.mean_freq  = (quotient > FREQ_MAX) ? FREQ_MAX : FREQ_W'(quotient);
            r.mean_valid = 1'b1;
        end else begin
            window_total = window_total + pair_acc;
        end
        slot_history[slot] = pair_acc;
        next_slot = (slot + 1 < RING_DEPTH) ? slot + 1 : 0;
        pair_acc = '0;
        expected_readings.push_back(r);
    endtask

    // idling only in two of every three stretches of 64 beats, never in the tail
    function automatic bit idling_allowed();
        return pending_counts.size() > CALM_TAIL && ((beats_in / 64) % 3) != 2;
    endfunction

    // output check first, then the model, so a new expectation never meets an old reading
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected reading: instant %0d mean %0d valid %0b",
                             m_tdata[19:0], m_tdata[39:20], m_tuser);
            end else begin
                reading_t want;
                want = expected_readings.pop_front();
                if (m_tdata[19:0] !== want.instant_freq || m_tdata[39:20] !== want.mean_freq
                        || m_tuser !== want.mean_valid) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < REPORT_LIMIT)
                        $display("reading mismatch: instant %0d/%0d mean %0d/%0d valid %0b/%0b",
                                 want.instant_freq, m_tdata[19:0], want.mean_freq,
                                 m_tdata[39:20], want.mean_valid, m_tuser);
                end
            end
        end
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            predict_count(s_tdata);
            beats_in <= beats_in + 1;
        end
    end

    // count driver: holds a beat until it is taken
    int unsigned send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                send_gap <= $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end else if (pending_counts.size() > 0) begin
                s_tdata  <= pending_counts.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // reading sink: random stalls plus one long hold-off to back up the pipeline
    int unsigned stall_left    = 0;
    bit          hold_off_done = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_off_done && beats_in >= HOLD_OFF_AT) begin
            hold_off_done <= 1'b1;
            stall_left    <= HOLD_OFF_CYCLES - 1;
            m_tready      <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_gated_frequency_counter_average failed");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        // extremes, alternating bits, carry into bit 16, then full-scale pairs for the window
        pending_counts = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                           16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                           16'h0001, 16'h0001, 16'h8000, 16'h7FFF};
        for (k = 0; k < 8; k++)
            pending_counts.push_back(16'hFFFF);
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            case ($urandom_range(0, 9))
                0:       pending_counts.push_back(16'hFFFF);
                1:       pending_counts.push_back(16'h0000);
                2, 3:    pending_counts.push_back(PULSE_W'($urandom_range(0, 255)));
                4:       pending_counts.push_back(16'hFFFF - PULSE_W'($urandom_range(0, 255)));
                default: pending_counts.push_back(PULSE_W'($urandom_range(0, 16'hFFFF)));
            endcase
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (pending_counts.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_readings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_gated_frequency_counter_average passed");
        end else begin
            $display("tb_gated_frequency_counter_average failed");
        end
        $finish;
    end

endmodule
